>>> hw/rtl/gsa_pkg.sv
package gsa_pkg;

  localparam int SLOTS    = 64;
  localparam int DEFAULTS = 6;
  localparam int IDX_W    = $clog2(SLOTS);
  localparam int CNT_W    = $clog2(SLOTS + 1);
  localparam int GEN_W    = 32;
  localparam int REV_W    = 32;

  typedef enum logic [1:0] {
    OP_ALLOCATE = 2'd0,
    OP_RELEASE  = 2'd1,
    OP_CHECK    = 2'd2,
    OP_QUERY    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_CAPACITY  = 2'd1,
    ST_INVALID   = 2'd2,
    ST_PROTECTED = 2'd3
  } status_t;

  typedef enum logic {
    FSM_IDLE,
    FSM_EXEC
  } fsm_state_t;

  typedef struct packed {
    op_t               op;
    logic [IDX_W-1:0]  slot_index;
    logic [GEN_W-1:0]  handle_generation;
  } req_item_t;

  typedef struct packed {
    status_t           status;
    logic [IDX_W-1:0]  out_index;
    logic [GEN_W-1:0]  out_generation;
    logic              slot_occupied;
    logic [REV_W-1:0]  slot_revision;
    logic [CNT_W-1:0]  live_count;
  } rsp_item_t;

  // one memory word per slot
  typedef struct packed {
    logic [IDX_W-1:0]  link;
    logic [GEN_W-1:0]  gen;
    logic [REV_W-1:0]  rev;
    logic              occ;
  } slot_entry_t;

  // contents of a slot that has not been written since reset
  function automatic slot_entry_t reset_entry(logic [IDX_W-1:0] idx);
    slot_entry_t e;
    e.link = '0;
    if (idx >= IDX_W'(DEFAULTS) && idx != IDX_W'(SLOTS - 1)) begin
      e.link = idx + IDX_W'(1);
    end
    e.gen = GEN_W'(1);
    e.rev = '0;
    e.occ = (idx < IDX_W'(DEFAULTS));
    return e;
  endfunction

endpackage

>>> hw/rtl/gsa_slot_ram.sv
module gsa_slot_ram (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      rd_en,
  input  logic [gsa_pkg::IDX_W-1:0] rd_addr,
  output gsa_pkg::slot_entry_t      rd_entry,
  input  logic                      wr_en,
  input  logic [gsa_pkg::IDX_W-1:0] wr_addr,
  input  gsa_pkg::slot_entry_t      wr_entry
);
  import gsa_pkg::*;

  slot_entry_t            mem [SLOTS];
  logic [SLOTS-1:0]       written;
  slot_entry_t            rd_data;
  logic                   rd_written;
  logic [IDX_W-1:0]       rd_addr_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // per-entry written flags stand in for the reset contents
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr_en) begin
      written[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_written <= written[rd_addr];
      rd_addr_q  <= rd_addr;
    end
  end

  assign rd_entry = rd_written ? rd_data : reset_entry(rd_addr_q);

endmodule

>>> hw/rtl/generational_slot_allocator.sv
// a request item is read from the slot memory, then executed once the output register can
//   take the result, which is registered there; no new item is taken until it has executed,
//   as the slot memory read comes before the read-modify-write of the addressed slot
// reset: synchronous, all slots take their reset contents at once through per-slot
//   written flags; no clearing pass, requests are taken from the first idle cycle
module generational_slot_allocator (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  gsa_pkg::req_item_t req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output gsa_pkg::rsp_item_t rsp
);
  import gsa_pkg::*;

  fsm_state_t        state;
  fsm_state_t        state_next;
  req_item_t         req_q;

  // list head and occupancy count
  logic [IDX_W-1:0]  free_head;
  logic [IDX_W-1:0]  free_head_next;
  logic [CNT_W-1:0]  count_live;
  logic [CNT_W-1:0]  count_live_next;

  logic              accept;
  logic              fire;
  logic [IDX_W-1:0]  rd_addr;
  slot_entry_t       entry;
  slot_entry_t       wr_entry;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  rsp_item_t         result;
  logic              handle_ok;
  logic [GEN_W-1:0]  gen_bumped;

  // allocate reads the list head, every other op reads the addressed slot
  assign rd_addr = (req.op == OP_ALLOCATE) ? free_head : req.slot_index;
  assign accept  = req_valid && req_ready;

  gsa_slot_ram u_ram (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (accept),
    .rd_addr  (rd_addr),
    .rd_entry (entry),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_entry (wr_entry)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      FSM_IDLE: begin
        if (accept) begin
          state_next = FSM_EXEC;
        end
      end
      FSM_EXEC: begin
        if (fire) begin
          state_next = FSM_IDLE;
        end
      end
      default: state_next = FSM_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    req_ready = 1'b0;
    fire      = 1'b0;
    unique case (state)
      FSM_IDLE: req_ready = 1'b1;
      // execute only once the output register can take the result
      FSM_EXEC: fire = !rsp_valid || rsp_ready;
      default: begin
        req_ready = 1'b0;
        fire      = 1'b0;
      end
    endcase
  end

  // handle check: slot index always lies below the slot count here
  assign handle_ok = entry.occ && (entry.gen == req_q.handle_generation);

  // generation after release, never zero
  always_comb begin
    gen_bumped = entry.gen + GEN_W'(1);
    if (gen_bumped == '0) begin
      gen_bumped = GEN_W'(1);
    end
  end

  // read-modify-write of the addressed slot
  always_comb begin
    free_head_next = free_head;
    count_live_next = count_live;
    wr_en    = 1'b0;
    wr_addr  = req_q.slot_index;
    wr_entry = entry;

    result.status         = ST_OK;
    result.out_index      = req_q.slot_index;
    result.out_generation = entry.gen;
    result.slot_occupied  = 1'b0;
    result.slot_revision  = '0;
    result.live_count     = count_live;

    case (req_q.op)
      OP_ALLOCATE: begin
        if (free_head == '0) begin
          // empty list, link value zero ends it
          result.status         = ST_CAPACITY;
          result.out_index      = '0;
          result.out_generation = '0;
        end else begin
          wr_en           = fire;
          wr_addr         = free_head;
          wr_entry.link   = '0;
          wr_entry.occ    = 1'b1;
          wr_entry.rev    = entry.rev + REV_W'(1);
          free_head_next  = entry.link;
          count_live_next = count_live + CNT_W'(1);
          result.out_index = free_head;
        end
      end
      OP_RELEASE: begin
        if (!handle_ok) begin
          result.status = ST_INVALID;
        end else if (req_q.slot_index < IDX_W'(DEFAULTS)) begin
          result.status = ST_PROTECTED;
        end else begin
          wr_en           = fire;
          wr_entry.link   = free_head;
          wr_entry.occ    = 1'b0;
          wr_entry.rev    = entry.rev + REV_W'(1);
          wr_entry.gen    = gen_bumped;
          free_head_next  = req_q.slot_index;
          count_live_next = count_live - CNT_W'(1);
          result.out_generation = gen_bumped;
        end
      end
      OP_CHECK: begin
        if (!handle_ok) begin
          result.status = ST_INVALID;
        end
      end
      default: begin
        // query
        result.slot_occupied = entry.occ;
        result.slot_revision = entry.rev;
      end
    endcase
    result.live_count = count_live_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= FSM_IDLE;
      free_head  <= IDX_W'(DEFAULTS);
      count_live <= CNT_W'(DEFAULTS);
    end else begin
      state <= state_next;
      if (fire) begin
        free_head  <= free_head_next;
        count_live <= count_live_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req;
    end
  end

  // output register parts the result from the next request
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fire) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp <= result;
    end
  end

endmodule

>>> bench/testbench.sv
module testbench;
  import gsa_pkg::*;

  // kinds of random stretch, each but the noise one biased toward some of the operations
  typedef enum int {
    PH_ALLOC,
    PH_RELEASE,
    PH_MIXED,
    PH_NOISE
  } phase_t;

  localparam int RANDOM_ITEMS  = 950;
  localparam int PHASE_LEN     = 100;
  localparam int LONG_HOLD_AT  = 300;
  localparam int LONG_HOLD_LEN = 400;
  localparam int PRINT_CAP     = 100;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_ready;
  req_item_t req = '0;
  logic      rsp_valid;
  logic      rsp_ready = 1'b0;
  rsp_item_t rsp;

  generational_slot_allocator DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // slot map mirror, advanced once per accepted request item
  // ---------------------------------------------------------------------------
  logic [IDX_W-1:0] slot_link [SLOTS];
  logic [GEN_W-1:0] slot_gen  [SLOTS];
  logic [REV_W-1:0] slot_rev  [SLOTS];
  logic             slot_busy [SLOTS];
  logic [IDX_W-1:0] free_top;
  logic [CNT_W-1:0] live_slots;

  req_item_t pending_q [$];
  rsp_item_t expected_q [$];

  int  error_count = 0;
  int  rsp_count = 0;
  int  send_gap = 0;
  int  rsp_hold = 0;
  bit  long_hold_done = 1'b0;
  bit  burst_mode = 1'b0;

  task automatic reset_slot_map();
    for (int i = 0; i < SLOTS; i++) begin
      // free chain runs upward from the first non-default slot, 0 ends it
      slot_link[i] = (i >= DEFAULTS && i + 1 < SLOTS) ? IDX_W'(i + 1) : '0;
      slot_gen[i]  = GEN_W'(1);
      slot_rev[i]  = '0;
      slot_busy[i] = (i < DEFAULTS);
    end
    free_top   = (SLOTS > DEFAULTS) ? IDX_W'(DEFAULTS) : '0;
    live_slots = CNT_W'(DEFAULTS);
  endtask

  // applies one operation to the mirror and returns the answer it must give
  task automatic apply_slot_op(input req_item_t r, output rsp_item_t ans);
    logic [IDX_W-1:0] s;
    bit               handle_live;
    ans           = '0;
    ans.status    = ST_OK;
    ans.out_index = r.slot_index;
    // a 6-bit index always addresses a slot of the 64
    s = r.slot_index;
    handle_live = slot_busy[s] && (slot_gen[s] == r.handle_generation);
    case (r.op)
      OP_ALLOCATE: begin
        if (free_top == '0 || int'(free_top) >= SLOTS) begin
          // empty free list: nothing changes
          ans.status    = ST_CAPACITY;
          ans.out_index = '0;
        end else begin
          s              = free_top;
          free_top       = slot_link[s];
          slot_link[s]   = '0;
          slot_busy[s]   = 1'b1;
          slot_rev[s]    = slot_rev[s] + REV_W'(1);
          live_slots     = live_slots + CNT_W'(1);
          ans.out_index  = s;
          ans.out_generation = slot_gen[s];
        end
      end
      OP_RELEASE: begin
        if (!handle_live) begin
          ans.status = ST_INVALID;
        end else if (int'(s) < DEFAULTS) begin
          ans.status = ST_PROTECTED;
        end else begin
          slot_busy[s] = 1'b0;
          slot_rev[s]  = slot_rev[s] + REV_W'(1);
          slot_gen[s]  = slot_gen[s] + GEN_W'(1);
          // generation 0 is reserved so that a zero handle never matches
          if (slot_gen[s] == '0) begin
            slot_gen[s] = GEN_W'(1);
          end
          slot_link[s] = free_top;
          free_top     = s;
          live_slots   = live_slots - CNT_W'(1);
        end
        ans.out_generation = slot_gen[s];
      end
      OP_CHECK: begin
        if (!handle_live) begin
          ans.status = ST_INVALID;
        end
        ans.out_generation = slot_gen[s];
      end
      default: begin
        ans.out_generation = slot_gen[s];
        ans.slot_occupied  = slot_busy[s];
        ans.slot_revision  = slot_rev[s];
      end
    endcase
    ans.live_count = live_slots;
  endtask

  task automatic report_mismatch(input string what);
    if (error_count < PRINT_CAP) begin
      $display("mismatch at %0t: %s", $time, what);
    end
    error_count++;
  endtask

  task automatic compare_answer(input rsp_item_t got, input rsp_item_t want);
    if (got.status !== want.status)
      report_mismatch($sformatf("answer %0d status got %0d want %0d",
                                rsp_count, got.status, want.status));
    if (got.out_index !== want.out_index)
      report_mismatch($sformatf("answer %0d out_index got %0d want %0d",
                                rsp_count, got.out_index, want.out_index));
    if (got.out_generation !== want.out_generation)
      report_mismatch($sformatf("answer %0d out_generation got %0h want %0h",
                                rsp_count, got.out_generation, want.out_generation));
    if (got.slot_occupied !== want.slot_occupied)
      report_mismatch($sformatf("answer %0d slot_occupied got %0b want %0b",
                                rsp_count, got.slot_occupied, want.slot_occupied));
    if (got.slot_revision !== want.slot_revision)
      report_mismatch($sformatf("answer %0d slot_revision got %0h want %0h",
                                rsp_count, got.slot_revision, want.slot_revision));
    if (got.live_count !== want.live_count)
      report_mismatch($sformatf("answer %0d live_count got %0d want %0d",
                                rsp_count, got.live_count, want.live_count));
  endtask

  // idle lengths: mostly none or short, now and then a long one
  function automatic int pick_gap();
    int r;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // random occupied slot above the defaults, -1 when there is none
  function automatic int find_live_slot();
    int start;
    int s;
    start = $urandom_range(0, SLOTS - 1);
    for (int k = 0; k < SLOTS; k++) begin
      s = (start + k) % SLOTS;
      if (s >= DEFAULTS && slot_busy[s]) return s;
    end
    return -1;
  endfunction

  // builds one random item from the mirror state so that most handles are live;
  // the mirror lags the queue by a few items, which turns some of them stale
  function automatic req_item_t make_item(input phase_t kind);
    req_item_t it;
    int        pick;
    int        s;
    int        a_lim;
    int        r_lim;
    int        c_lim;
    int        q_lim;
    it.op                = op_t'($urandom_range(0, 3));
    it.slot_index        = IDX_W'($urandom_range(0, SLOTS - 1));
    it.handle_generation = $urandom();
    case (kind)
      PH_ALLOC:   begin a_lim = 70; r_lim = 80; c_lim = 85; q_lim = 90; end
      PH_RELEASE: begin a_lim = 15; r_lim = 70; c_lim = 80; q_lim = 90; end
      PH_MIXED:   begin a_lim = 35; r_lim = 65; c_lim = 75; q_lim = 85; end
      default:    return it;
    endcase
    pick = $urandom_range(0, 99);
    if (pick < a_lim) begin
      it.op = OP_ALLOCATE;
    end else if (pick < c_lim) begin
      // live handle; now and then one of the protected defaults
      it.op = (pick < r_lim) ? OP_RELEASE : OP_CHECK;
      s = find_live_slot();
      if (s < 0 || $urandom_range(0, 9) == 0) s = $urandom_range(0, DEFAULTS - 1);
      it.slot_index        = IDX_W'(s);
      it.handle_generation = slot_gen[s];
    end else if (pick < q_lim) begin
      it.op = OP_QUERY;
    end else begin
      // broken handle: stale, ahead, zero or garbage generation
      it.op = $urandom_range(0, 1) ? OP_RELEASE : OP_CHECK;
      s = int'(it.slot_index);
      case ($urandom_range(0, 3))
        0:       it.handle_generation = slot_gen[s] - GEN_W'(1);
        1:       it.handle_generation = slot_gen[s] + GEN_W'(1);
        2:       it.handle_generation = '0;
        default: begin end
      endcase
    end
    return it;
  endfunction

  task automatic push_item(input op_t op, input int idx, input logic [GEN_W-1:0] g);
    req_item_t it;
    it.op                = op;
    it.slot_index        = IDX_W'(idx);
    it.handle_generation = g;
    pending_q.insert(pending_q.size(), it);
  endtask

  // ---------------------------------------------------------------------------
  // stimulus: directed opening, then random phases; the queue is kept short
  // so that live handles are picked from a nearly current mirror
  // ---------------------------------------------------------------------------
  initial begin
    phase_t kind;
    reset_slot_map();
    kind = PH_ALLOC;

    // defaults: occupied, valid at generation 1, never released
    push_item(OP_QUERY,    0,  32'd0);
    push_item(OP_QUERY,    63, 32'd0);
    push_item(OP_CHECK,    0,  32'd1);
    push_item(OP_CHECK,    5,  32'd1);
    push_item(OP_RELEASE,  0,  32'd1);
    push_item(OP_RELEASE,  5,  32'd1);
    // zero generation, garbage generation, free slots
    push_item(OP_RELEASE,  3,  32'd0);
    push_item(OP_CHECK,    2,  32'hFFFF_FFFF);
    push_item(OP_CHECK,    6,  32'd1);
    push_item(OP_RELEASE,  63, 32'd1);
    // allocate, check, release with wrong then right generation, double release
    push_item(OP_ALLOCATE, 63, 32'hFFFF_FFFF);
    push_item(OP_CHECK,    6,  32'd1);
    push_item(OP_CHECK,    6,  32'd0);
    push_item(OP_RELEASE,  6,  32'd2);
    push_item(OP_RELEASE,  6,  32'd1);
    push_item(OP_RELEASE,  6,  32'd2);
    push_item(OP_QUERY,    6,  32'd0);
    // lifo order of the free list
    push_item(OP_ALLOCATE, 0,  32'd0);
    push_item(OP_ALLOCATE, 0,  32'd0);
    push_item(OP_RELEASE,  7,  32'd1);
    push_item(OP_RELEASE,  6,  32'd2);
    push_item(OP_ALLOCATE, 0,  32'd0);
    push_item(OP_QUERY,    7,  32'd0);
    push_item(OP_CHECK,    6,  32'd3);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      while (pending_q.size() >= 3) @(negedge clk);
      if (n % PHASE_LEN == 0) begin
        // first phase fills the map so the capacity limit is hit early
        if (n != 0) kind = phase_t'($urandom_range(0, 3));
        burst_mode = ($urandom_range(0, 3) == 0);
      end
      pending_q.insert(pending_q.size(), make_item(kind));
    end

    do @(negedge clk); while (pending_q.size() != 0 || req_valid);
    while (expected_q.size() != 0) @(negedge clk);
    // wait on to catch a stray answer
    repeat (10) @(negedge clk);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // request side: offers queued items with random gaps between them
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      send_gap  <= 0;
    end else if (req_valid && !req_ready) begin
      // item still on offer, payload held
    end else if (send_gap != 0) begin
      send_gap  <= send_gap - 1;
      req_valid <= 1'b0;
    end else if (pending_q.size() != 0) begin
      req       <= pending_q.pop_front();
      req_valid <= 1'b1;
      send_gap  <= pick_gap();
    end else begin
      req_valid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // answer side: random stalls, plus one long hold-off that backs up the block
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
      rsp_hold  <= 0;
    end else if (!long_hold_done && rsp_count >= LONG_HOLD_AT) begin
      long_hold_done <= 1'b1;
      rsp_hold       <= LONG_HOLD_LEN;
      rsp_ready      <= 1'b0;
    end else if (rsp_hold != 0) begin
      rsp_hold  <= rsp_hold - 1;
      rsp_ready <= 1'b0;
    end else if (burst_mode || $urandom_range(0, 3) != 0) begin
      rsp_ready <= 1'b1;
    end else begin
      rsp_hold  <= pick_gap();
      rsp_ready <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predicts on request acceptance, checks answers in order
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    rsp_item_t want;
    if (!rst) begin
      if (req_valid && req_ready) begin
        apply_slot_op(req, want);
        expected_q.insert(expected_q.size(), want);
      end
      if (rsp_valid && rsp_ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("answer %0d arrived with nothing outstanding",
                                    rsp_count));
        end else begin
          compare_answer(rsp, expected_q.pop_front());
        end
        rsp_count <= rsp_count + 1;
      end
    end
  end

endmodule
